// ----- rtl/core/ssp_pkg.sv -----
// ---------------------------------------------------------------------------
// Sum-sorted pair table: shared definitions
// Codes, payload types and helper functions used by the cells and the
// top level.
// ---------------------------------------------------------------------------
package ssp_pkg;

	// Default number of cells in the chain.
	localparam int unsigned DEPTH_DEFAULT = 16;

	// Operation codes carried by the action field of an input item.
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_PURGE  = 2'd1,
		ACT_FIND   = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	// Predicate codes; the fourth code matches no pair.
	typedef enum logic [1:0] {
		PRED_LESS        = 2'd0,
		PRED_BOTH_EVEN   = 2'd1,
		PRED_SECOND_ZERO = 2'd2
	} pred_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	// What every cell does in a given cycle.
	typedef enum logic [1:0] {
		CELL_HOLD    = 2'd0,
		CELL_INSERT  = 2'd1,
		CELL_MARK    = 2'd2,
		CELL_COMPACT = 2'd3
	} cell_op_t;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_COMPACT,
		S_GATHER,
		S_POST
	} state_t;

	// One stored pair together with its 33-bit sum.
	typedef struct packed {
		logic signed [31:0] first;
		logic signed [31:0] second;
		logic signed [32:0] sum;
	} pair_t;

	// Broadcast control shared by all cells.
	typedef struct packed {
		cell_op_t   op;
		logic [1:0] predicate;
		pair_t      fresh;
	} cell_ctrl_t;

	// Per-cell control from the top level and the neighbouring cells.
	typedef struct packed {
		logic occupied;
		logic sel_in;
		logic le_left;
		logic hole_left;
		logic hole_right;
	} cell_nbr_t;

	// Per-cell status flags.
	typedef struct packed {
		logic le;
		logic hole;
		logic match;
		logic sel;
	} cell_stat_t;

	// A pending result waiting for the output register.
	typedef struct packed {
		status_t            status;
		logic signed [31:0] first;
		logic signed [31:0] second;
	} res_t;

	// Sum of a pair, formed one bit wider so that it cannot overflow.
	function automatic logic signed [32:0] pair_sum(logic signed [31:0] a,
			logic signed [31:0] b);
		pair_sum = {a[31], a} + {b[31], b};
	endfunction

	// Predicate test on one pair.
	function automatic logic pair_match(logic [1:0] pred, logic signed [31:0] a,
			logic signed [31:0] b);
		case (pred)
			PRED_LESS:        pair_match = (a < b);
			PRED_BOTH_EVEN:   pair_match = !a[0] && !b[0];
			PRED_SECOND_ZERO: pair_match = (b == 32'sd0);
			default:          pair_match = 1'b0;
		endcase
	endfunction

endpackage

// ----- rtl/core/ssp_cmd_if.sv -----
// ---------------------------------------------------------------------------
// Sum-sorted pair table: command channel
// Valid/ready channel carrying one operation item into the table.
// ---------------------------------------------------------------------------
interface ssp_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [31:0] first_value;
	logic signed [31:0] second_value;
	logic [1:0]         predicate;
	logic [3:0]         position;

	modport source (output valid, action, first_value, second_value, predicate,
		position, input ready);
	modport sink (input valid, action, first_value, second_value, predicate,
		position, output ready);
endinterface

// ----- rtl/core/ssp_res_if.sv -----
// ---------------------------------------------------------------------------
// Sum-sorted pair table: result channel
// Valid/ready channel carrying one result item out of the table.
// ---------------------------------------------------------------------------
interface ssp_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] result_first;
	logic signed [31:0] result_second;
	logic [4:0]         entry_count;

	modport source (output valid, status, result_first, result_second,
		entry_count, input ready);
	modport sink (input valid, status, result_first, result_second,
		entry_count, output ready);
endinterface

// ----- rtl/core/sum_sorted_pair_table_unit.sv -----
// ---------------------------------------------------------------------------
// Sum-sorted pair table
// A chain of cells holding up to DEPTH signed pairs in ascending order of
// their sum, with insert, purge, find-last and read-at-position operations.
// ---------------------------------------------------------------------------
//
// Channel  Modport  Item contents
// cmd      sink     action, first_value, second_value, predicate, position
// res      source   status, result_first, result_second, entry_count
//
// Insert passes through the execute and post states to the result register;
// find and read also pass the gather state, since the selection flags are registered.
// Purge marks holes, then runs compaction steps of the cell chain, at most
// DEPTH steps, as holes bubble one cell per cycle towards the tail.
// Reset clears the state, the count and the flags; stored pairs are undefined
// until written, and no clearing pass is run.
// A result waiting in the output register stalls the sequencer in its final
// state; the next item is accepted in the cycle the result register frees.
//
module sum_sorted_pair_table_unit #(
	parameter int unsigned DEPTH = ssp_pkg::DEPTH_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	ssp_cmd_if.sink    cmd,
	ssp_res_if.source  res
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	ssp_pkg::state_t     state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	ssp_pkg::res_t       res_q, res_d;
	ssp_pkg::cell_ctrl_t ctrl;
	ssp_pkg::cell_op_t   cell_op;
	ssp_pkg::cell_nbr_t  nbr   [DEPTH];
	ssp_pkg::cell_stat_t stat  [DEPTH];
	ssp_pkg::pair_t      entry [DEPTH];

	logic [1:0]          act_s1;
	logic signed [31:0]  first_s1;
	logic signed [31:0]  second_s1;
	logic [1:0]          pred_s1;
	logic [3:0]          pos_s1;

	logic [DEPTH-1:0]    match_vec;
	logic [DEPTH-1:0]    hole_vec;
	logic [DEPTH-1:0]    sel_vec;
	logic [DEPTH-1:0]    swap_vec;
	logic                swap_any;
	logic                full;
	logic                accept;
	logic                out_free;
	logic [CW-1:0]       purge_count;
	logic signed [31:0]  gath_first;
	logic signed [31:0]  gath_second;

	logic                out_valid_q;
	ssp_pkg::res_t       out_q;
	logic [CW-1:0]       out_count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign out_free = !out_valid_q || res.ready;
	assign accept   = cmd.valid && cmd.ready;

	// Captured command item.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1    <= cmd.action;
			first_s1  <= cmd.first_value;
			second_s1 <= cmd.second_value;
			pred_s1   <= cmd.predicate;
			pos_s1    <= cmd.position;
		end
	end

	// Broadcast control for the chain.
	assign ctrl.op           = cell_op;
	assign ctrl.predicate    = pred_s1;
	assign ctrl.fresh.first  = first_s1;
	assign ctrl.fresh.second = second_s1;
	assign ctrl.fresh.sum    = ssp_pkg::pair_sum(first_s1, second_s1);

	// The cell chain with its neighbour links.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic above;

		assign match_vec[i] = stat[i].match;
		assign hole_vec[i]  = stat[i].hole;
		assign sel_vec[i]   = stat[i].sel;
		assign above        = |(match_vec >> (i + 1));

		assign nbr[i].occupied = (CW'(i) < count_q);
		assign nbr[i].sel_in   = (act_s1 == ssp_pkg::ACT_READ) ?
			(nbr[i].occupied && (32'(pos_s1) == 32'(i))) :
			(match_vec[i] && !above);

		if (i == 0) begin : g_head
			assign nbr[i].le_left   = 1'b1;
			assign nbr[i].hole_left = 1'b0;
		end else begin : g_body
			assign nbr[i].le_left   = stat[i-1].le;
			assign nbr[i].hole_left = stat[i-1].hole;
		end

		if (i == DEPTH - 1) begin : g_tail
			assign nbr[i].hole_right = 1'b1;
		end else begin : g_inner
			assign nbr[i].hole_right = stat[i+1].hole;
		end

		assign swap_vec[i] = hole_vec[i] && !nbr[i].hole_right;

		ssp_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.nbr         (nbr[i]),
			.left_entry  ((i == 0) ? ctrl.fresh : entry[(i == 0) ? 0 : i - 1]),
			.right_entry ((i == DEPTH - 1) ? entry[i] :
				entry[(i == DEPTH - 1) ? i : i + 1]),
			.entry       (entry[i]),
			.stat        (stat[i])
		);
	end

	assign swap_any = |swap_vec;

	// Count after compaction: the index of the first hole.
	always_comb begin
		logic any_hole;
		logic first_hole;
		purge_count = '0;
		any_hole    = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			first_hole = hole_vec[i] && ((i == 0) || !hole_vec[(i == 0) ? 0 : i - 1]);
			if (first_hole) begin
				purge_count = purge_count | CW'(i);
			end
			any_hole = any_hole | first_hole;
		end
		if (!any_hole) begin
			purge_count = CW'(DEPTH);
		end
	end

	// Gather the selected pair; at most one cell is selected.
	always_comb begin
		gath_first  = '0;
		gath_second = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (sel_vec[i]) begin
				gath_first  = gath_first | entry[i].first;
				gath_second = gath_second | entry[i].second;
			end
		end
	end

	// Sequencer: next state, cell operation and pending result.
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		res_d      = res_q;
		cell_op    = ssp_pkg::CELL_HOLD;
		cmd.ready  = 1'b0;
		unique case (state_q)
			ssp_pkg::S_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = ssp_pkg::S_EXEC;
				end
			end
			ssp_pkg::S_EXEC: begin
				res_d.first  = '0;
				res_d.second = '0;
				res_d.status = ssp_pkg::ST_OK;
				unique case (act_s1)
					ssp_pkg::ACT_INSERT: begin
						if (full) begin
							res_d.status = ssp_pkg::ST_FULL;
						end else begin
							cell_op = ssp_pkg::CELL_INSERT;
							count_d = count_q + 1'b1;
						end
						state_d = ssp_pkg::S_POST;
					end
					ssp_pkg::ACT_PURGE: begin
						cell_op = ssp_pkg::CELL_MARK;
						state_d = ssp_pkg::S_COMPACT;
					end
					default: begin
						cell_op = ssp_pkg::CELL_MARK;
						state_d = ssp_pkg::S_GATHER;
					end
				endcase
			end
			ssp_pkg::S_COMPACT: begin
				if (swap_any) begin
					cell_op = ssp_pkg::CELL_COMPACT;
				end else begin
					count_d = purge_count;
					state_d = ssp_pkg::S_POST;
				end
			end
			ssp_pkg::S_GATHER: begin
				if (|sel_vec) begin
					res_d.status = ssp_pkg::ST_OK;
					res_d.first  = gath_first;
					res_d.second = gath_second;
				end else begin
					res_d.status = ssp_pkg::ST_MISS;
					res_d.first  = '0;
					res_d.second = '0;
				end
				state_d = ssp_pkg::S_POST;
			end
			ssp_pkg::S_POST: begin
				if (out_free) begin
					cmd.ready = 1'b1;
					state_d   = cmd.valid ? ssp_pkg::S_EXEC : ssp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ssp_pkg::S_IDLE;
			end
		endcase
	end

	// State, count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssp_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == ssp_pkg::S_POST && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pending result and output register payload.
	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (state_q == ssp_pkg::S_POST && out_free) begin
			out_q       <= res_q;
			out_count_q <= count_q;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.status        = out_q.status;
	assign res.result_first  = out_q.first;
	assign res.result_second = out_q.second;
	assign res.entry_count   = 5'(out_count_q);

	// The stored count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("stored count above table depth");

	// An accepted item is always executed in the following cycle.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ssp_pkg::S_EXEC)
		else $error("accepted item not executed");

	// Find and read select at most one cell.
	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ssp_pkg::S_GATHER |-> $onehot0(sel_vec))
		else $error("more than one cell selected");

	// A purge never grows the table.
	a_purge_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssp_pkg::S_COMPACT && !swap_any) |=> count_q <= $past(count_q))
		else $error("purge grew the table");

	// An insert into a table with room adds exactly one pair.
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssp_pkg::S_EXEC && act_s1 == ssp_pkg::ACT_INSERT && !full)
		|=> count_q == CW'($past(count_q) + 1'b1))
		else $error("insert did not add one pair");

endmodule

// ----- rtl/core/ssp_cell.sv -----
// ---------------------------------------------------------------------------
// Sum-sorted pair table: storage cell
// Holds one pair and its sum, takes part in ordered insertion by taking the new
// pair or shifting from its left neighbour, and in purge compaction by swapping
// with its neighbours.
// ---------------------------------------------------------------------------
module ssp_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  ssp_pkg::cell_ctrl_t ctrl,
	input  ssp_pkg::cell_nbr_t  nbr,
	input  ssp_pkg::pair_t      left_entry,
	input  ssp_pkg::pair_t      right_entry,
	output ssp_pkg::pair_t      entry,
	output ssp_pkg::cell_stat_t stat
);

	ssp_pkg::pair_t entry_q;
	logic           hole_q;
	logic           sel_q;
	logic           le;
	logic           match;
	logic           swap_in;
	logic           swap_out;

	// The stored pair belongs at or before the new pair in sum order.
	assign le    = nbr.occupied && (entry_q.sum <= ctrl.fresh.sum);
	assign match = nbr.occupied &&
		ssp_pkg::pair_match(ctrl.predicate, entry_q.first, entry_q.second);

	// A hole swaps with a kept pair on its right.
	assign swap_in  = hole_q && !nbr.hole_right;
	assign swap_out = !hole_q && nbr.hole_left;

	// Pair storage; no reset, entries are only read once written.
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			ssp_pkg::CELL_INSERT: begin
				if (!le) begin
					entry_q <= nbr.le_left ? ctrl.fresh : left_entry;
				end
			end
			ssp_pkg::CELL_COMPACT: begin
				if (swap_in) begin
					entry_q <= right_entry;
				end else if (swap_out) begin
					entry_q <= left_entry;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	// Hole and selection flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_q <= 1'b0;
			sel_q  <= 1'b0;
		end else begin
			unique case (ctrl.op)
				ssp_pkg::CELL_MARK: begin
					hole_q <= !nbr.occupied || match;
					sel_q  <= nbr.sel_in;
				end
				ssp_pkg::CELL_COMPACT: begin
					if (swap_in) begin
						hole_q <= 1'b0;
					end else if (swap_out) begin
						hole_q <= 1'b1;
					end
				end
				default: begin
					hole_q <= hole_q;
				end
			endcase
		end
	end

	assign entry      = entry_q;
	assign stat.le    = le;
	assign stat.hole  = hole_q;
	assign stat.match = match;
	assign stat.sel   = sel_q;

endmodule
